// ----- rtl/klt_pkg.sv -----
// ----------------------------------------------------------------------------
// klt_pkg
// Shared types and constants for the keyed list table: command codes,
// decoded operations, result status codes, queue entry and back-end states.
// ----------------------------------------------------------------------------
package klt_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_SEARCH,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_tag;
    } q_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_EXEC
    } bk_state_t;

endpackage

// ----- rtl/klt_front.sv -----
// ----------------------------------------------------------------------------
// klt_front
// Command intake: decodes the command code into an operation and pushes the
// decoded command into the queue when a command is valid and the queue has room.
// ----------------------------------------------------------------------------
module klt_front (
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [klt_pkg::CMD_W-1:0]           cmd,
    input  logic signed [klt_pkg::KEY_W-1:0]    key,
    input  logic [klt_pkg::VAL_W-1:0]           value_tag,
    input  logic                                q_full,
    output logic                                q_push,
    output klt_pkg::q_entry_t                   q_entry
);
    import klt_pkg::*;

    op_t op_dec;

    always_comb
    begin
        unique case (cmd)
            CMD_INSERT: op_dec = OP_INSERT;
            CMD_REMOVE: op_dec = OP_REMOVE;
            CMD_SEARCH: op_dec = OP_SEARCH;
            default:    op_dec = OP_NOP;
        endcase
    end

    assign cmd_ready         = !q_full;
    assign q_push            = cmd_valid && !q_full;
    assign q_entry.op        = op_dec;
    assign q_entry.key       = key;
    assign q_entry.value_tag = value_tag;

endmodule

// ----- rtl/klt_queue.sv -----
// ----------------------------------------------------------------------------
// klt_queue
// Short command queue between intake and execution so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module klt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  klt_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output klt_pkg::q_entry_t head_entry,
    output logic              empty
);
    import klt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign empty      = (occ_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/klt_back.sv -----
// ----------------------------------------------------------------------------
// klt_back
// Table execution: a row of key/value cells with per-cell compare, first
// match priority, one-step compaction on remove, and the result register.
// ----------------------------------------------------------------------------
module klt_back #(
    parameter int DEPTH = klt_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  klt_pkg::q_entry_t             q_head,
    output logic                          q_pop,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          found,
    output logic [klt_pkg::POS_W-1:0]     position,
    output logic [klt_pkg::VAL_W-1:0]     match_value,
    output logic [klt_pkg::CNT_W-1:0]     entry_count,
    output logic [klt_pkg::STATUS_W-1:0]  status
);
    import klt_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNTI_W = $clog2(DEPTH + 1);

    bk_state_t state_reg, state_next;

    logic [KEY_W-1:0]  tbl_key_reg [DEPTH];
    logic [VAL_W-1:0]  tbl_val_reg [DEPTH];
    logic [CNTI_W-1:0] count_reg, count_next;

    op_t               cur_op_reg;
    logic [KEY_W-1:0]  cur_key_reg;
    logic [VAL_W-1:0]  cur_val_reg;
    logic [DEPTH-1:0]  hit_reg, hit_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic                found_reg, found_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0]    mval_reg, mval_next;
    logic [CNT_W-1:0]    cnt_out_reg;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              fire;
    logic [DEPTH-1:0]  hit_first;
    logic [DEPTH-1:0]  at_or_above;
    logic              any_hit;
    logic              tbl_full;
    logic [IDX_W-1:0]  hit_idx;
    logic [VAL_W-1:0]  hit_val;
    logic              do_insert;
    logic              do_remove;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_MATCH;
                end
            end
            BK_MATCH:
            begin
                state_next = BK_EXEC;
            end
            BK_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    fire = 1'b1;
                    if (!q_empty)
                    begin
                        q_pop      = 1'b1;
                        state_next = BK_MATCH;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Hold the command being executed.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_op_reg  <= q_head.op;
            cur_key_reg <= q_head.key;
            cur_val_reg <= q_head.value_tag;
        end
    end

    // ---------------- per-cell compare ----------------
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_next[i] = (tbl_key_reg[i] == cur_key_reg) && (CNTI_W'(i) < count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_MATCH)
        begin
            hit_reg <= hit_next;
        end
    end

    // ---------------- first match and result ----------------
    assign hit_first   = hit_reg & (~hit_reg + 1'b1);
    assign at_or_above = ~(hit_first - 1'b1);
    assign any_hit     = |hit_reg;
    assign tbl_full    = (count_reg == CNTI_W'(DEPTH));

    always_comb
    begin
        hit_idx = '0;
        hit_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_first[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
                hit_val = hit_val | tbl_val_reg[i];
            end
        end
    end

    always_comb
    begin
        found_next  = 1'b0;
        pos_next    = '0;
        mval_next   = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        unique case (cur_op_reg)
            OP_INSERT:
            begin
                if (tbl_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    pos_next   = POS_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!any_hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    found_next = 1'b1;
                    pos_next   = POS_W'(hit_idx);
                    count_next = count_reg - 1'b1;
                end
            end
            OP_SEARCH:
            begin
                if (!any_hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    found_next = 1'b1;
                    pos_next   = POS_W'(hit_idx);
                    mval_next  = hit_val;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign do_insert = fire && (cur_op_reg == OP_INSERT) && !tbl_full;
    assign do_remove = fire && (cur_op_reg == OP_REMOVE) && any_hit;

    // ---------------- table cells ----------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g < DEPTH - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (do_insert && (count_reg == CNTI_W'(g)))
                begin
                    tbl_key_reg[g] <= cur_key_reg;
                    tbl_val_reg[g] <= cur_val_reg;
                end
                else if (do_remove && at_or_above[g])
                begin
                    // pull the next entry down to close the gap
                    tbl_key_reg[g] <= tbl_key_reg[g+1];
                    tbl_val_reg[g] <= tbl_val_reg[g+1];
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (do_insert && (count_reg == CNTI_W'(g)))
                begin
                    tbl_key_reg[g] <= cur_key_reg;
                    tbl_val_reg[g] <= cur_val_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        priority if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            found_reg   <= found_next;
            pos_reg     <= pos_next;
            mval_reg    <= mval_next;
            cnt_out_reg <= CNT_W'(count_next);
            status_reg  <= status_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign position    = pos_reg;
    assign match_value = mval_reg;
    assign entry_count = cnt_out_reg;
    assign status      = status_reg;

endmodule

// ----- rtl/keyed_list_table_with_compaction_core.sv -----
// ----------------------------------------------------------------------------
// keyed_list_table_with_compaction_core
// Flow: a command passes the queue, then the compare and execute steps of the
// table back end, which then registers the result; the execute step stalls while an
// earlier result waits for rsp_ready. One command at a time is in the table.
// Reset: table empty (count zero), queue emptied, result valid cleared, no sweep.
// ----------------------------------------------------------------------------
module keyed_list_table_with_compaction_core #(
    parameter int DEPTH = klt_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  logic [klt_pkg::CMD_W-1:0]        cmd,
    input  logic signed [klt_pkg::KEY_W-1:0] key,
    input  logic [klt_pkg::VAL_W-1:0]        value_tag,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic                             found,
    output logic [klt_pkg::POS_W-1:0]        position,
    output logic [klt_pkg::VAL_W-1:0]        match_value,
    output logic [klt_pkg::CNT_W-1:0]        entry_count,
    output logic [klt_pkg::STATUS_W-1:0]     status
);
    import klt_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    q_entry_t q_in;
    q_entry_t q_head;

    klt_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .key       (key),
        .value_tag (value_tag),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    klt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_entry (q_head),
        .empty      (q_empty)
    );

    klt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .found       (found),
        .position    (position),
        .match_value (match_value),
        .entry_count (entry_count),
        .status      (status)
    );

`ifndef ASSERT_OFF
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into a full queue");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && found) |-> (status == ST_OK))
        else $error("match reported with a failure status");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL)) |->
        (!found && position == '0 && match_value == '0))
        else $error("failed command carries match data");
`endif

endmodule
